// File: design/frame_size_quality_controller_defines.svh
// assertion macros for the frame size quality controller
// no dependencies; included by the top level
`ifndef FRAME_SIZE_QUALITY_CONTROLLER_DEFINES_SVH
`define FRAME_SIZE_QUALITY_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FSQC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define FSQC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define FSQC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSQC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/fsqc_pkg.sv
// shared widths, register indexes, constants and control structs
// no dependencies
package fsqc_pkg;

  localparam int BYTES_W    = 40;
  localparam int FRAME_W    = 32;
  localparam int LIMIT_W    = 32;
  localparam int QUAL_W     = 7;
  localparam int HOLD_W     = 5;
  localparam int DIVR_W     = FRAME_W + 1;
  localparam int DIV_STEPS  = BYTES_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_QUALITY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_QUALITY_LOCK = 2'd2;

  localparam logic [QUAL_W-1:0] QUAL_RESET = 7'd80;
  localparam logic [QUAL_W-1:0] QUAL_FLOOR = 7'd10;
  localparam logic [QUAL_W-1:0] QUAL_CEIL  = 7'd95;
  localparam logic [QUAL_W-1:0] STEP_SMALL = 7'd1;
  localparam logic [QUAL_W-1:0] STEP_MID   = 7'd3;
  localparam logic [QUAL_W-1:0] STEP_LARGE = 7'd5;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 5'd4;
  localparam int HOLD_FRAMES_DEF = 16;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scale;
    logic compare;
    logic update;
  } fsqc_cmd_t;

  typedef struct packed {
    logic div_last;
  } fsqc_sts_t;

endpackage

// File: design/fsqc_ctrl.sv
// sequencer for one frame step: load, serial divide, scale, compare, update
// depends on fsqc_pkg
module fsqc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fsqc_pkg::fsqc_sts_t sts,
  output fsqc_pkg::fsqc_cmd_t cmd
);
  import fsqc_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_SCALE, ST_CMP, ST_UPD} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/fsqc_datapath.sv
// config registers, controller state, bit-serial divider, threshold compare
// and output register; depends on fsqc_pkg
module fsqc_datapath #(
  parameter int HOLD_FRAMES = fsqc_pkg::HOLD_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fsqc_pkg::fsqc_cmd_t             cmd,
  output fsqc_pkg::fsqc_sts_t             sts,
  input  logic [fsqc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            cfg_wr_en,
  input  logic [fsqc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fsqc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [fsqc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fsqc_pkg::*;

  localparam int A10_W = BYTES_W + 4;
  localparam int A2_W  = BYTES_W + 1;
  localparam int L11_W = LIMIT_W + 4;
  localparam int L3_W  = LIMIT_W + 2;
  localparam int L2_W  = LIMIT_W + 1;

  // configuration and step state
  logic [LIMIT_W-1:0] limit_r;
  logic               lock_r;
  logic [QUAL_W-1:0]  quality_r, quality_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic [BYTES_W-1:0] base_bytes_r, base_bytes_nxt;
  logic [FRAME_W-1:0] base_frame_r, base_frame_nxt;
  logic               fired;

  // per-item datapath
  logic [BYTES_W-1:0] in_bytes, bytes_r, diff_bytes;
  logic [FRAME_W-1:0] in_frame, frame_r;
  logic [DIVR_W-1:0]  divisor_r, rem_r, rem_nxt;
  logic [BYTES_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIVR_W:0]    trial, trial_diff;
  logic               trial_ge;

  logic [A10_W-1:0]   a10_r;
  logic [A2_W-1:0]    a2_r;
  logic [L11_W-1:0]   l11_r, l9_r;
  logic [L3_W-1:0]    l3_r;
  logic [L2_W-1:0]    l2_r;
  logic               over_r, under_r, big2_r, big15_r;
  logic [QUAL_W-1:0]  step;

  logic [QUAL_W-1:0]  out_quality_r;
  logic [BYTES_W-1:0] out_avg_r;
  logic               out_adj_r;

  assign in_bytes   = in_tdata[BYTES_W-1:0];
  assign in_frame   = in_tdata[BYTES_W +: FRAME_W];
  assign diff_bytes = (in_bytes >= base_bytes_r) ? (in_bytes - base_bytes_r) : '0;

  // restoring divide, one quotient bit per step
  assign trial      = {rem_r, quo_r[BYTES_W-1]};
  assign trial_ge   = trial >= {1'b0, divisor_r};
  assign trial_diff = trial - {1'b0, divisor_r};
  assign rem_nxt    = trial_ge ? trial_diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
  assign quo_nxt    = {quo_r[BYTES_W-2:0], trial_ge};

  assign sts.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  assign step = big2_r ? STEP_LARGE : (big15_r ? STEP_MID : STEP_SMALL);

  always_comb begin
    quality_nxt    = quality_r;
    hold_nxt       = hold_r;
    base_bytes_nxt = base_bytes_r;
    base_frame_nxt = base_frame_r;
    fired          = 1'b0;
    if (!lock_r && (over_r || under_r)) begin
      if (hold_r == '0) begin
        if (over_r) begin
          quality_nxt = (quality_r < QUAL_FLOOR + step) ? QUAL_FLOOR : (quality_r - step);
        end else begin
          quality_nxt = (quality_r >= QUAL_CEIL) ? QUAL_CEIL : (quality_r + STEP_SMALL);
        end
        hold_nxt       = HOLD_W'(HOLD_FRAMES);
        base_bytes_nxt = bytes_r;
        base_frame_nxt = frame_r;
        fired          = 1'b1;
      end else begin
        hold_nxt = hold_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= '0;
      lock_r       <= 1'b0;
      quality_r    <= QUAL_RESET;
      hold_r       <= HOLD_RESET;
      base_bytes_r <= '0;
      base_frame_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_FRAME_LIMIT:  limit_r   <= cfg_wdata[LIMIT_W-1:0];
          REG_INIT_QUALITY: quality_r <= cfg_wdata[QUAL_W-1:0];
          REG_QUALITY_LOCK: lock_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        quality_r    <= quality_nxt;
        hold_r       <= hold_nxt;
        base_bytes_r <= base_bytes_nxt;
        base_frame_r <= base_frame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bytes_r   <= in_bytes;
      frame_r   <= in_frame;
      divisor_r <= {1'b0, in_frame - base_frame_r} + DIVR_W'(1);
      rem_r     <= '0;
      quo_r     <= diff_bytes;
      cnt_r     <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.scale) begin
      a10_r <= A10_W'({quo_r, 3'b000}) + A10_W'({quo_r, 1'b0});
      a2_r  <= {quo_r, 1'b0};
      l11_r <= L11_W'({limit_r, 3'b000}) + L11_W'({limit_r, 1'b0}) + L11_W'(limit_r);
      l9_r  <= L11_W'({limit_r, 3'b000}) + L11_W'(limit_r);
      l3_r  <= L3_W'({limit_r, 1'b0}) + L3_W'(limit_r);
      l2_r  <= {limit_r, 1'b0};
    end
    if (cmd.compare) begin
      over_r  <= a10_r > A10_W'(l11_r);
      under_r <= a10_r < A10_W'(l9_r);
      big2_r  <= quo_r > BYTES_W'(l2_r);
      big15_r <= a2_r > A2_W'(l3_r);
    end
    if (cmd.update) begin
      out_quality_r <= quality_nxt;
      out_avg_r     <= quo_r;
      out_adj_r     <= fired;
    end
  end

  assign out_tdata = {out_adj_r, out_avg_r, out_quality_r};

endmodule

// File: design/frame_size_quality_controller.sv
// frame size quality controller: one result per frame transfer
// sequence: the operands load at the input transfer, then the bit-serial divide steps,
//   scale, compare and update follow; out_tvalid rises with the update
// the bit-serial 40-bit divider handles one frame at a time, so a new frame is taken
//   only once the last one is through; a result still held by the receiver stalls the update step
// reset (rst_n low, synchronous): quality 80, hold count 4, origins 0, limit 0,
//   unlocked; the output register keeps one finished result while the next frame runs
`include "frame_size_quality_controller_defines.svh"

module frame_size_quality_controller #(
  parameter int HOLD_FRAMES = fsqc_pkg::HOLD_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fsqc_pkg::IN_DATA_W-1:0]  in_tdata,   // bytes_written[39:0], frame_number[71:40]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fsqc_pkg::OUT_DATA_W-1:0] out_tdata,  // quality[6:0], average_size[46:7],
                                                      // adjusted[47]
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [fsqc_pkg::CFG_ADDR_W-1:0] cfg_addr,   // 0 limit, 1 initial quality, 2 lock
  input  logic [fsqc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fsqc_pkg::*;

  // controller to datapath commands and back
  fsqc_cmd_t cmd;
  fsqc_sts_t sts;

  // the sequencer owns the handshakes; the output valid flag lives there
  fsqc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // all arithmetic, state and the result register
  fsqc_datapath #(
    .HOLD_FRAMES (HOLD_FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

  // a frame transfer starts the divide, so the input side closes right after it
  `FSQC_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a result the receiver has not taken stays offered and unchanged
  `FSQC_ASSERT_NXT(a_out_held, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule
